// ===== rtl/core/hsl_saturation_scale_core_assert.svh =====
// Assertion macros used by the saturation scaler top level
`ifndef HSL_SATURATION_SCALE_CORE_ASSERT_SVH
`define HSL_SATURATION_SCALE_CORE_ASSERT_SVH

// check a condition in the same cycle as its trigger
`define HSS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// check a condition in the cycle after its trigger
`define HSS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/hss_pkg.sv =====
// Shared constants and types of the HSL saturation scaler
package hss_pkg;

   localparam int PIXEL_BITS_DEF = 8;
   localparam int Q_W = 17;
   localparam int ONE_Q16 = 65536;
   localparam int HALF_Q16 = 32768;
   localparam int HUE_W = 22;
   localparam int GAIN_W = 16;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;
   localparam int CSR_W = 32;
   localparam logic [1:0] SAT_GAIN_ADDR = 2'd0;
   localparam int DIV_NUM_W = 34;
   localparam int DIV_DEN_W = 18;

   typedef struct packed {
      logic [Q_W-1:0] light;
      logic [Q_W-1:0] sat;
      logic signed [HUE_W-1:0] hue;
   } hsl_type;

endpackage

// ===== rtl/core/hss_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
module hss_div #(
   parameter int NUM_W = hss_pkg::DIV_NUM_W,
   parameter int DEN_W = hss_pkg::DIV_DEN_W,
   parameter int QUO_W = hss_pkg::Q_W,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              src_valid,
   input  logic [NUM_W-1:0]  src_num,
   input  logic [DEN_W-1:0]  src_den,
   input  logic [SIDE_W-1:0] src_side,
   output logic              dst_valid,
   output logic [QUO_W-1:0]  dst_quo,
   output logic [SIDE_W-1:0] dst_side
);

   localparam int CMP_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic              vld_ff  [QUO_W];
   logic [NUM_W-1:0]  rem_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int SH = QUO_W - 1 - k;
      logic              vld_src;
      logic [NUM_W-1:0]  rem_src;
      logic [DEN_W-1:0]  den_src;
      logic [QUO_W-1:0]  quo_src;
      logic [SIDE_W-1:0] side_src;
      logic [CMP_W-1:0]  trial;
      logic [CMP_W-1:0]  diff;
      logic              take;
      logic [NUM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (k == 0) begin : g_first
         assign vld_src  = src_valid;
         assign rem_src  = src_num;
         assign den_src  = src_den;
         assign quo_src  = '0;
         assign side_src = src_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign trial  = CMP_W'(den_src) << SH;
      assign diff   = CMP_W'(rem_src) - trial;
      assign take   = CMP_W'(rem_src) >= trial;
      assign rem_in = take ? diff[NUM_W-1:0] : rem_src;
      assign quo_in = quo_src | (take ? (QUO_W'(1) << SH) : '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_src;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign dst_valid = vld_ff[QUO_W-1];
   assign dst_quo   = quo_ff[QUO_W-1];
   assign dst_side  = side_ff[QUO_W-1];

endmodule

// ===== rtl/core/hss_rgb.sv =====
// HSL to RGB back conversion and rescale to pixel codes
module hss_rgb #(
   parameter int PIXEL_BITS = hss_pkg::PIXEL_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    src_valid,
   input  hss_pkg::hsl_type        src_hsl,
   input  logic                    src_unity,
   input  logic [3*PIXEL_BITS-1:0] src_codes,
   output logic                    dst_valid,
   output logic [PIXEL_BITS-1:0]   dst_blue,
   output logic [PIXEL_BITS-1:0]   dst_green,
   output logic [PIXEL_BITS-1:0]   dst_red
);

   localparam int P = PIXEL_BITS;
   localparam int CW = 3 * P;
   localparam int QW = hss_pkg::Q_W;
   localparam int HW = hss_pkg::HUE_W;
   localparam logic [P-1:0] CODE_MAX = P'((1 << P) - 1);
   localparam logic [QW-1:0] ONE = QW'(hss_pkg::ONE_Q16);
   localparam logic [QW-1:0] HALF = QW'(hss_pkg::HALF_Q16);
   localparam logic signed [HW-1:0] S_ONE = HW'(hss_pkg::ONE_Q16);
   localparam logic signed [HW-1:0] S_THREE = HW'(3 * hss_pkg::ONE_Q16);
   localparam logic signed [HW-1:0] S_FOUR = HW'(4 * hss_pkg::ONE_Q16);
   localparam logic signed [HW-1:0] S_SIX = HW'(6 * hss_pkg::ONE_Q16);

   // lightness stage: m2 and m1
   logic              low;
   logic [QW:0]       mul_b;
   logic [2*QW:0]     prod_e;
   logic [QW+1:0]     rnd_e;
   logic signed [18:0] m2_c;
   logic signed [18:0] m1_c;

   assign low    = src_hsl.light <= HALF;
   assign mul_b  = low ? ((QW+1)'(ONE) + (QW+1)'(src_hsl.sat)) : (QW+1)'(src_hsl.sat);
   assign prod_e = (2*QW+1)'(src_hsl.light) * (2*QW+1)'(mul_b);
   assign rnd_e  = (QW+2)'(((2*QW+1)'(prod_e) + (2*QW+1)'(HALF)) >> 16);
   assign m2_c   = low ? $signed(19'(rnd_e))
                       : $signed(19'(src_hsl.light)) + $signed(19'(src_hsl.sat))
                         - $signed(19'(rnd_e));
   assign m1_c   = $signed({1'b0, src_hsl.light, 1'b0}) - m2_c;

   logic                  vld_e_ff;
   logic signed [18:0]    m1_ff;
   logic signed [18:0]    m2_ff;
   logic signed [HW-1:0]  hue_ff;
   logic                  unity_e_ff;
   logic [CW-1:0]         codes_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_e_ff <= 1'b0;
      end else if (adv) begin
         vld_e_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff      <= m1_c;
         m2_ff      <= m2_c;
         hue_ff     <= src_hsl.hue;
         unity_e_ff <= src_unity;
         codes_e_ff <= src_codes;
      end
   end

   logic [17:0] span;
   assign span = 18'(m2_ff - m1_ff);

   logic                  vld_f_ff;
   logic                  unity_f_ff;
   logic [CW-1:0]         codes_f_ff;
   logic signed [19:0]    val_ff  [3];
   logic [P-1:0]          code_ff [3];

   // lanes: 0 blue, 1 green, 2 red
   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam logic signed [HW-1:0] OFF = HW'((i - 1) * 2 * hss_pkg::ONE_Q16);
      logic signed [HW-1:0] hw_a;
      logic signed [HW-1:0] hw_b;
      logic [QW-1:0]        wgt;
      logic [2*QW:0]        prod_f;
      logic [18:0]          blend;
      logic signed [19:0]   val_in;
      logic [QW-1:0]        vc;
      logic [QW+P:0]        prod_g;
      logic [P+1:0]         cfull;
      logic [P-1:0]         code_in;

      always_comb begin
         hw_a = hue_ff + OFF;
         if (hw_a > S_SIX) begin
            hw_b = hw_a - S_SIX;
         end else if (hw_a < 0) begin
            hw_b = hw_a + S_SIX;
         end else begin
            hw_b = hw_a;
         end
         if (hw_b < S_ONE) begin
            wgt = hw_b[QW-1:0];
         end else begin
            wgt = QW'(S_FOUR - hw_b);
         end
         prod_f = (2*QW+1)'(span) * (2*QW+1)'(wgt);
         blend  = 19'((prod_f + (2*QW+1)'(HALF)) >> 16);
         if (hw_b < S_ONE) begin
            val_in = 20'(m1_ff) + $signed({1'b0, blend});
         end else if (hw_b < S_THREE) begin
            val_in = 20'(m2_ff);
         end else if (hw_b < S_FOUR) begin
            val_in = 20'(m1_ff) + $signed({1'b0, blend});
         end else begin
            val_in = 20'(m1_ff);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            val_ff[i] <= val_in;
         end
      end

      always_comb begin
         if (val_ff[i] < 0) begin
            vc = '0;
         end else if (val_ff[i] > $signed(20'(ONE))) begin
            vc = ONE;
         end else begin
            vc = val_ff[i][QW-1:0];
         end
         prod_g  = (QW+P+1)'(vc) * (QW+P+1)'(CODE_MAX);
         cfull   = (P+2)'((prod_g + (QW+P+1)'(HALF)) >> 16);
         code_in = (cfull > (P+2)'(CODE_MAX)) ? CODE_MAX : cfull[P-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            code_ff[i] <= unity_f_ff ? codes_f_ff[i*P +: P] : code_in;
         end
      end
   end

   logic vld_g_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_f_ff <= 1'b0;
         vld_g_ff <= 1'b0;
      end else if (adv) begin
         vld_f_ff <= vld_e_ff;
         vld_g_ff <= vld_f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         unity_f_ff <= unity_e_ff;
         codes_f_ff <= codes_e_ff;
      end
   end

   assign dst_valid = vld_g_ff;
   assign dst_blue  = code_ff[0];
   assign dst_green = code_ff[1];
   assign dst_red   = code_ff[2];

endmodule

// ===== rtl/core/hsl_saturation_scale_core.sv =====
// Top level of the HSL saturation scaler: front end, dividers and CSR
// Throughput: one pixel per cycle; a stalled result freezes the whole pipeline.
// Most of the depth lies in the 17-stage dividers for saturation and hue.
// Reset clears every valid bit and sets sat_gain to 4096 (unity).
module hsl_saturation_scale_core #(
   parameter int PIXEL_BITS = hss_pkg::PIXEL_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PIXEL_BITS-1:0]    req_in_blue,
   input  logic [PIXEL_BITS-1:0]    req_in_green,
   input  logic [PIXEL_BITS-1:0]    req_in_red,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PIXEL_BITS-1:0]    rsp_out_blue,
   output logic [PIXEL_BITS-1:0]    rsp_out_green,
   output logic [PIXEL_BITS-1:0]    rsp_out_red,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [1:0]               paddr,
   input  logic [hss_pkg::CSR_W-1:0] pwdata,
   output logic [hss_pkg::CSR_W-1:0] prdata,
   output logic                     pready
);

`include "hsl_saturation_scale_core_assert.svh"

   localparam int P = PIXEL_BITS;
   localparam int CW = 3 * P;
   localparam int QW = hss_pkg::Q_W;
   localparam int HW = hss_pkg::HUE_W;
   localparam int REP = (QW + P - 1) / P;
   localparam int DNW = hss_pkg::DIV_NUM_W;
   localparam int DDW = hss_pkg::DIV_DEN_W;
   localparam int GW = hss_pkg::GAIN_W;
   localparam logic [QW-1:0] ONE = QW'(hss_pkg::ONE_Q16);
   localparam logic [QW-1:0] HALF = QW'(hss_pkg::HALF_Q16);
   localparam logic signed [HW-1:0] S_SIX = HW'(6 * hss_pkg::ONE_Q16);
   localparam int SIDE_C = QW + 1 + CW;

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // configuration
   logic          csr_wr;
   logic [GW-1:0] gain_ff;

   assign csr_wr = psel && penable && pwrite && paddr == hss_pkg::SAT_GAIN_ADDR;
   assign pready = 1'b1;
   assign prdata = hss_pkg::CSR_W'(gain_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= hss_pkg::GAIN_UNITY;
      end else if (csr_wr) begin
         gain_ff <= pwdata[GW-1:0];
      end
   end

   // input register
   logic          vld0_ff;
   logic          unity0_ff;
   logic [CW-1:0] codes0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         codes0_ff <= {req_in_red, req_in_green, req_in_blue};
         unity0_ff <= gain_ff == hss_pkg::GAIN_UNITY;
      end
   end

   // normalize each component to Q1.16: code / (2^P - 1) repeats the code bits
   logic [REP*P-1:0] rep   [3];
   logic [QW-1:0]    cq_in [3];

   for (genvar i = 0; i < 3; i++) begin : g_norm
      assign rep[i]   = {REP{codes0_ff[i*P +: P]}};
      assign cq_in[i] = QW'(rep[i][REP*P-1 -: QW-1]) + QW'(rep[i][REP*P-QW]);
   end

   logic          vld_n_ff;
   logic [QW-1:0] cq_ff [3];
   logic          unity_n_ff;
   logic [CW-1:0] codes_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_n_ff <= 1'b0;
      end else if (adv) begin
         vld_n_ff <= vld0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cq_ff      <= cq_in;
         unity_n_ff <= unity0_ff;
         codes_n_ff <= codes0_ff;
      end
   end

   // extremes, lightness and division operands
   logic [QW-1:0]   mx;
   logic [QW-1:0]   mn;
   logic [QW:0]     sum;
   logic [QW-1:0]   light;
   logic [QW-1:0]   delta;
   logic [QW:0]     den_s;
   logic signed [QW:0] hdif;
   logic [2:0]      base;

   always_comb begin
      mx = (cq_ff[0] > cq_ff[1]) ? cq_ff[0] : cq_ff[1];
      if (cq_ff[2] > mx) begin
         mx = cq_ff[2];
      end
      mn = (cq_ff[0] < cq_ff[1]) ? cq_ff[0] : cq_ff[1];
      if (cq_ff[2] < mn) begin
         mn = cq_ff[2];
      end
      sum   = (QW+1)'(mx) + (QW+1)'(mn);
      light = QW'((sum + (QW+1)'(1)) >> 1);
      delta = mx - mn;
      den_s = (light <= HALF) ? sum : ((QW+1)'(2 * hss_pkg::ONE_Q16) - sum);
      if (mx == cq_ff[2]) begin
         base = 3'd0;
         hdif = $signed({1'b0, cq_ff[1]}) - $signed({1'b0, cq_ff[0]});
      end else if (mx == cq_ff[1]) begin
         base = 3'd2;
         hdif = $signed({1'b0, cq_ff[0]}) - $signed({1'b0, cq_ff[2]});
      end else begin
         base = 3'd4;
         hdif = $signed({1'b0, cq_ff[2]}) - $signed({1'b0, cq_ff[1]});
      end
   end

   logic          vld_b_ff;
   logic [QW:0]   den_s_ff;
   logic [QW-1:0] delta_ff;
   logic [QW-1:0] mag_ff;
   logic          neg_ff;
   logic [2:0]    base_ff;
   logic [QW-1:0] light_ff;
   logic          unity_b_ff;
   logic [CW-1:0] codes_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (adv) begin
         vld_b_ff <= vld_n_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_s_ff   <= den_s;
         delta_ff   <= delta;
         mag_ff     <= QW'(hdif < 0 ? -hdif : hdif);
         neg_ff     <= hdif < 0;
         base_ff    <= base;
         light_ff   <= light;
         unity_b_ff <= unity_n_ff;
         codes_b_ff <= codes_n_ff;
      end
   end

   // saturation and hue dividers
   logic [DNW-1:0]    s_num;
   logic [DNW-1:0]    h_num;
   logic              vld_c;
   logic [QW-1:0]     sq;
   logic [QW-1:0]     hq;
   logic [SIDE_C-1:0] side_c;
   logic [3:0]        side_h;
   logic              dummy_h;

   assign s_num = DNW'({delta_ff, 16'b0}) + DNW'(den_s_ff >> 1);
   assign h_num = DNW'({mag_ff, 16'b0}) + DNW'(delta_ff >> 1);

   hss_div #(.NUM_W(DNW), .DEN_W(DDW), .QUO_W(QW), .SIDE_W(SIDE_C)) u_div_sat (
      .clock(clock), .reset(reset), .adv(adv),
      .src_valid(vld_b_ff), .src_num(s_num), .src_den(DDW'(den_s_ff)),
      .src_side({light_ff, unity_b_ff, codes_b_ff}),
      .dst_valid(vld_c), .dst_quo(sq), .dst_side(side_c)
   );

   hss_div #(.NUM_W(DNW), .DEN_W(QW), .QUO_W(QW), .SIDE_W(4)) u_div_hue (
      .clock(clock), .reset(reset), .adv(adv),
      .src_valid(vld_b_ff), .src_num(h_num), .src_den(delta_ff),
      .src_side({neg_ff, base_ff}),
      .dst_valid(dummy_h), .dst_quo(hq), .dst_side(side_h)
   );

   // hue assembly and saturation gain
   logic [2:0]         base_c;
   logic               neg_c;
   logic signed [HW-1:0] hbase;
   logic signed [HW-1:0] hqs;
   logic signed [HW-1:0] h_raw;
   logic signed [HW-1:0] h_fix;
   logic [QW-1:0]      s_cl;
   logic [QW+GW-1:0]   sprod;
   logic [QW+GW-13:0]  s2w;
   logic [QW-1:0]      s2;
   hss_pkg::hsl_type   hsl_in;

   always_comb begin
      neg_c  = side_h[3];
      base_c = side_h[2:0];
      hbase  = $signed(HW'({base_c, 16'b0}));
      hqs    = $signed(HW'(hq));
      h_raw  = neg_c ? (hbase - hqs) : (hbase + hqs);
      h_fix  = (h_raw < 0) ? (h_raw + S_SIX) : h_raw;
      s_cl   = (sq > ONE) ? ONE : sq;
      sprod  = (QW+GW)'(s_cl) * (QW+GW)'(gain_ff) + (QW+GW)'(2048);
      s2w    = sprod[QW+GW-1:12];
      s2     = (s2w > (QW+GW-12)'(ONE)) ? ONE : s2w[QW-1:0];
      hsl_in.light = side_c[SIDE_C-1 -: QW];
      hsl_in.sat   = s2;
      hsl_in.hue   = h_fix;
   end

   logic             vld_d_ff;
   hss_pkg::hsl_type hsl_ff;
   logic             unity_d_ff;
   logic [CW-1:0]    codes_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d_ff <= 1'b0;
      end else if (adv) begin
         vld_d_ff <= vld_c;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hsl_ff     <= hsl_in;
         unity_d_ff <= side_c[CW];
         codes_d_ff <= side_c[CW-1:0];
      end
   end

   hss_rgb #(.PIXEL_BITS(PIXEL_BITS)) u_rgb (
      .clock(clock), .reset(reset), .adv(adv),
      .src_valid(vld_d_ff), .src_hsl(hsl_ff),
      .src_unity(unity_d_ff), .src_codes(codes_d_ff),
      .dst_valid(rsp_valid),
      .dst_blue(rsp_out_blue), .dst_green(rsp_out_green), .dst_red(rsp_out_red)
   );

   `HSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `HSS_ASSERT_NOW(a_freeze_input, rsp_valid && rsp_stall, req_stall)
   `HSS_ASSERT_NEXT(a_gain_write, csr_wr, gain_ff == $past(pwdata[GW-1:0]))
   `HSS_ASSERT_NOW(a_div_lockstep, vld_c || dummy_h, vld_c == dummy_h)

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the HSL saturation scaler core
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PB = hss_pkg::PIXEL_BITS_DEF;
   localparam int LATENCY = 23;
   localparam longint ONE = 65536;
   localparam longint HALF = 32768;

   typedef struct packed {
      logic [PB-1:0] blue;
      logic [PB-1:0] green;
      logic [PB-1:0] red;
   } pixel_type;

   typedef struct {
      logic [15:0] gain;
      pixel_type   pix;
      bit          typed;
      pixel_type   want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [PB-1:0] req_in_blue;
   logic [PB-1:0] req_in_green;
   logic [PB-1:0] req_in_red;
   logic rsp_valid;
   logic rsp_stall;
   logic [PB-1:0] rsp_out_blue;
   logic [PB-1:0] rsp_out_green;
   logic [PB-1:0] rsp_out_red;
   logic psel;
   logic penable;
   logic pwrite;
   logic [1:0] paddr;
   logic [hss_pkg::CSR_W-1:0] pwdata;
   logic [hss_pkg::CSR_W-1:0] prdata;
   logic pready;

   pixel_type pending_pixels[$];
   logic [15:0] cur_gain;
   int mismatches;
   bit calm;

   hsl_saturation_scale_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic longint q16_mul(longint a, longint t);
      return round_div(a * t, ONE);
   endfunction

   function automatic longint hue_channel(longint n1, longint n2, longint h);
      if (h > 6 * ONE) h -= 6 * ONE;
      else if (h < 0) h += 6 * ONE;
      if (h < ONE) return n1 + q16_mul(n2 - n1, h);
      if (h < 3 * ONE) return n2;
      if (h < 4 * ONE) return n1 + q16_mul(n2 - n1, 4 * ONE - h);
      return n1;
   endfunction

   function automatic logic [PB-1:0] level_to_code(longint v);
      longint m;
      longint c;
      m = (1 << PB) - 1;
      if (v < 0) v = 0;
      if (v > ONE) v = ONE;
      c = (v * m + HALF) / ONE;
      if (c > m) c = m;
      return c[PB-1:0];
   endfunction

   function automatic pixel_type scale_saturation(logic [15:0] gain, pixel_type p);
      longint m, cb, cg, cr, mx, mn, sum, delta, l, s, h, s2, m1, m2;
      pixel_type r;
      m = (1 << PB) - 1;
      if (gain == hss_pkg::GAIN_UNITY) return p;
      cb = (longint'(p.blue) * ONE + m / 2) / m;
      cg = (longint'(p.green) * ONE + m / 2) / m;
      cr = (longint'(p.red) * ONE + m / 2) / m;
      mx = cb > cg ? cb : cg;
      if (cr > mx) mx = cr;
      mn = cb < cg ? cb : cg;
      if (cr < mn) mn = cr;
      sum = mx + mn;
      l = (sum + 1) >>> 1;
      s = 0;
      h = 0;
      if (mx != mn) begin
         delta = mx - mn;
         if (l <= HALF) s = round_div(delta * ONE, sum);
         else s = round_div(delta * ONE, 2 * ONE - sum);
         if (s > ONE) s = ONE;
         if (mx == cr) h = round_div((cg - cb) * ONE, delta);
         else if (mx == cg) h = 2 * ONE + round_div((cb - cr) * ONE, delta);
         else h = 4 * ONE + round_div((cr - cg) * ONE, delta);
         if (h < 0) h += 6 * ONE;
      end
      s2 = (s * longint'(gain) + 2048) >>> 12;
      if (s2 > ONE) s2 = ONE;
      if (s2 == 0) begin
         r.blue = level_to_code(l);
         r.green = level_to_code(l);
         r.red = level_to_code(l);
      end else begin
         if (l <= HALF) m2 = q16_mul(l, ONE + s2);
         else m2 = l + s2 - q16_mul(l, s2);
         m1 = 2 * l - m2;
         r.red = level_to_code(hue_channel(m1, m2, h + 2 * ONE));
         r.green = level_to_code(hue_channel(m1, m2, h));
         r.blue = level_to_code(hue_channel(m1, m2, h - 2 * ONE));
      end
      return r;
   endfunction

   task automatic drain();
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_gain(logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= hss_pkg::SAT_GAIN_ADDR;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cur_gain = value[15:0];
   endtask

   task automatic send_pixel(pixel_type p, bit typed, pixel_type want);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_blue <= p.blue;
      req_in_green <= p.green;
      req_in_red <= p.red;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_pixels.push_back(typed ? want : scale_saturation(cur_gain, p));
   endtask

   task automatic set_gain_idle(logic [31:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      drain();
      write_gain(value);
   endtask

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !calm && ($urandom_range(99) < 8);
   end

   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_blue, rsp_out_green, rsp_out_red};
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", got);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch b/g/r expected %h %h %h got %h %h %h",
                     want.blue, want.green, want.red, got.blue, got.green, got.red);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      logic [31:0] gains[7];
      pixel_type p;
      int k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_blue = '0;
      req_in_green = '0;
      req_in_red = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = hss_pkg::SAT_GAIN_ADDR;
      pwdata = '0;
      mismatches = 0;
      calm = 1'b0;
      cur_gain = hss_pkg::GAIN_UNITY;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unity gain after reset passes pixels through
      rows.push_back('{16'd4096, '{8'h00, 8'h00, 8'h00}, 1, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd4096, '{8'hff, 8'hff, 8'hff}, 1, '{8'hff, 8'hff, 8'hff}});
      rows.push_back('{16'd4096, '{8'h12, 8'hc3, 8'hff}, 1, '{8'h12, 8'hc3, 8'hff}});
      rows.push_back('{16'd4096, '{8'hff, 8'h00, 8'h55}, 1, '{8'hff, 8'h00, 8'h55}});
      // gray stays gray at any gain, then colored pixels at several gains checked against scale_saturation
      rows.push_back('{16'd0, '{8'h80, 8'h80, 8'h80}, 1, '{8'h80, 8'h80, 8'h80}});
      rows.push_back('{16'd0, '{8'hff, 8'h00, 8'h00}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd0, '{8'h10, 8'h90, 8'h40}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd65535, '{8'h00, 8'h00, 8'h00}, 1, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd65535, '{8'hff, 8'hff, 8'hff}, 1, '{8'hff, 8'hff, 8'hff}});
      rows.push_back('{16'd65535, '{8'h40, 8'h60, 8'h80}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd65535, '{8'h80, 8'h20, 8'h60}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd65535, '{8'h20, 8'hc0, 8'hb0}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd2048, '{8'hff, 8'h00, 8'h00}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd2048, '{8'h00, 8'hff, 8'h00}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd2048, '{8'h00, 8'h00, 8'hff}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd2048, '{8'hc8, 8'he0, 8'hf0}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd2048, '{8'h01, 8'h03, 8'h02}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd8192, '{8'h7f, 8'h80, 8'h81}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd8192, '{8'hfe, 8'hff, 8'hfd}, 0, '{8'h00, 8'h00, 8'h00}});
      rows.push_back('{16'd8192, '{8'h33, 8'h66, 8'h99}, 0, '{8'h00, 8'h00, 8'h00}});

      foreach (rows[i]) begin
         if (rows[i].gain != cur_gain) set_gain_idle({16'h0, rows[i].gain});
         send_pixel(rows[i].pix, rows[i].typed, rows[i].want);
      end

      gains = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_1000, 32'ha5a5_0800,
                32'h5a5a_2000, 32'h0000_1001, 32'h0000_0fff};
      for (int ph = 0; ph < 7; ph++) begin
         set_gain_idle(ph == 6 ? $urandom : gains[ph]);
         calm = (ph == 3);
         for (k = 0; k < 250; k++) begin
            p = (3*PB)'($urandom);
            if ($urandom_range(9) == 0) p.green = p.blue;
            if ($urandom_range(19) == 0) begin
               p.green = p.blue;
               p.red = p.blue;
            end
            send_pixel(p, 0, p);
         end
         calm = 1'b0;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end
endmodule
